// ===== rtl/ktmf_pkg.sv =====
// Shared types, constants and helper functions of the keypoint temporal median filter.
// Depends on nothing; every other file of the block but ktmf_ram imports it.
package ktmf_pkg;

	// sizing of the block
	localparam int WINDOW     = 5;
	localparam int POINTS     = 21;
	localparam int COORD_BITS = 24;

	// fixed widths of the channel fields
	localparam int IDX_W      = 5;
	localparam int FIELD_BITS = 24;
	localparam int AXES       = 3;

	// derived widths
	localparam int ROWS    = WINDOW * POINTS;
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int POINT_W = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int ADDR_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WIDE    = 34;
	localparam int MID     = WINDOW / 2;

	// one sample or median for all three axes
	typedef logic [AXES-1:0][COORD_BITS-1:0] triple_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              wr;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_slot;
		logic              rank_en;
		logic [SLOT_W-1:0] rank_sel;
		logic              emit;
	} ktmf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_ok;
		logic out_free;
	} ktmf_sts_t;

	// sign-extend a field and saturate it to the internal coordinate range
	function automatic logic [COORD_BITS-1:0] take_coord(input logic signed [FIELD_BITS-1:0] raw);
		logic signed [WIDE-1:0] v;
		logic signed [WIDE-1:0] hi;
		logic signed [WIDE-1:0] lo;
		v  = WIDE'(raw);
		hi = (WIDE'(1) <<< (COORD_BITS - 1)) - WIDE'(1);
		lo = -hi - WIDE'(1);
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[COORD_BITS-1:0];
	endfunction

	// bring an internal coordinate back to the field width
	function automatic logic signed [FIELD_BITS-1:0] to_field(input logic [COORD_BITS-1:0] c);
		logic signed [WIDE-1:0] w;
		w = WIDE'($signed(c));
		return w[FIELD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/ktmf_if.sv =====
// Channel interfaces of the keypoint temporal median filter: points in, medians out.
// Depends on ktmf_pkg for the field widths.
interface ktmf_pt_if import ktmf_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [IDX_W-1:0]             point_index;
	logic signed [FIELD_BITS-1:0] coord_x;
	logic signed [FIELD_BITS-1:0] coord_y;
	logic signed [FIELD_BITS-1:0] coord_z;
	logic                         frame_end;

	modport source (output valid, point_index, coord_x, coord_y, coord_z, frame_end,
		input ready);
	modport sink (input valid, point_index, coord_x, coord_y, coord_z, frame_end,
		output ready);
endinterface

interface ktmf_med_if import ktmf_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [IDX_W-1:0]             out_index;
	logic signed [FIELD_BITS-1:0] median_x;
	logic signed [FIELD_BITS-1:0] median_y;
	logic signed [FIELD_BITS-1:0] median_z;
	logic                         frame_changed;
	logic                         out_frame_end;

	modport source (output valid, out_index, median_x, median_y, median_z, frame_changed,
		out_frame_end, input ready);
	modport sink (input valid, out_index, median_x, median_y, median_z, frame_changed,
		out_frame_end, output ready);
endinterface

// ===== rtl/ktmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ktmf_ram #(
	parameter int   WIDTH = 8,
	parameter int   DEPTH = 16,
	localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ktmf_ctrl.sv =====
// Sequencer of the keypoint temporal median filter: input handshake and step order.
// Depends on ktmf_pkg; drives the datapath through ktmf_cmd_t.
module ktmf_ctrl import ktmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ktmf_sts_t sts,
	output ktmf_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WRITE = 5'b00010,
		S_READ  = 5'b00100,
		S_RANK  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		cmd.rd_slot  = cnt_q[SLOT_W-1:0];
		cmd.rank_sel = cnt_q[SLOT_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				cmd.load = accept;
				if (accept) state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.wr = sts.idx_ok;
				cnt_d  = '0;
				state_d = sts.idx_ok ? S_READ : S_DONE;
			end
			S_READ: begin
				// one slot a cycle, then a final pass with no read while the last read data lands in its lane
				cmd.rd_en = (cnt_q != CNT_W'(WINDOW));
				if (cnt_q == CNT_W'(WINDOW)) begin
					cnt_d   = '0;
					state_d = S_RANK;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_RANK: begin
				cmd.rank_en = 1'b1;
				if (cnt_q == CNT_W'(WINDOW - 1)) begin
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_DONE: begin
				// hand the result over once the output register is free
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/ktmf_dp.sv =====
// Datapath of the keypoint temporal median filter: window store, rank selection,
// previous medians, change tracking and output register. Depends on ktmf_pkg, ktmf_ram.
module ktmf_dp import ktmf_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ktmf_cmd_t                    cmd,
	output ktmf_sts_t                    sts,
	input  logic [IDX_W-1:0]             in_index,
	input  logic signed [FIELD_BITS-1:0] in_x,
	input  logic signed [FIELD_BITS-1:0] in_y,
	input  logic signed [FIELD_BITS-1:0] in_z,
	input  logic                         in_frame_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [IDX_W-1:0]             out_index,
	output logic signed [FIELD_BITS-1:0] median_x,
	output logic signed [FIELD_BITS-1:0] median_y,
	output logic signed [FIELD_BITS-1:0] median_z,
	output logic                         frame_changed,
	output logic                         out_frame_end
);

	logic [IDX_W-1:0]  idx_q;
	triple_t           sample_q;
	logic              fe_q;
	logic              idx_ok;
	logic [POINT_W-1:0] point_row;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [ROWS-1:0]   row_valid_q;
	logic              rd_valid_s1;
	logic              cap_en_s1;
	logic [SLOT_W-1:0] cap_lane_s1;
	triple_t           ram_rdata;
	triple_t           lane_q [WINDOW];
	triple_t           cand;
	logic [AXES-1:0]   hit;
	triple_t           med_q;
	triple_t           prev_q [POINTS];
	logic              change_seen_q;
	logic              diff;
	logic              change_now;
	logic              out_valid_q;

	// capture the accepted point, coordinates already saturated
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q       <= in_index;
			sample_q[0] <= take_coord(in_x);
			sample_q[1] <= take_coord(in_y);
			sample_q[2] <= take_coord(in_z);
			fe_q        <= in_frame_end;
		end
	end

	assign idx_ok    = {1'b0, idx_q} < (IDX_W + 1)'(POINTS);
	assign point_row = idx_q[POINT_W-1:0];

	// row address: slot major, point minor
	assign waddr = ADDR_W'(slot_q) * ADDR_W'(POINTS) + ADDR_W'(idx_q);
	assign raddr = ADDR_W'(cmd.rd_slot) * ADDR_W'(POINTS) + ADDR_W'(idx_q);

	ktmf_ram #(
		.WIDTH ($bits(triple_t)),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (waddr),
		.wdata (sample_q),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// rows never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			cap_en_s1   <= 1'b0;
		end else begin
			if (cmd.wr) row_valid_q[waddr] <= 1'b1;
			cap_en_s1 <= cmd.rd_en;
		end
	end

	// read side info aligned with the ram output
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_valid_s1 <= row_valid_q[raddr];
			cap_lane_s1 <= cmd.rd_slot;
		end
	end

	// gather the window into lanes
	always_ff @(posedge clk) begin
		if (cap_en_s1) lane_q[cap_lane_s1] <= rd_valid_s1 ? ram_rdata : '0;
	end

	// rank the selected candidate against the whole window, per axis
	always_comb begin
		logic [CNT_W-1:0] n_lt;
		logic [CNT_W-1:0] n_le;
		cand = lane_q[cmd.rank_sel];
		for (int a = 0; a < AXES; a++) begin
			n_lt = '0;
			n_le = '0;
			for (int j = 0; j < WINDOW; j++) begin
				n_lt = n_lt + CNT_W'($signed(lane_q[j][a]) < $signed(cand[a]));
				n_le = n_le + CNT_W'($signed(lane_q[j][a]) <= $signed(cand[a]));
			end
			hit[a] = (n_lt <= CNT_W'(MID)) && (n_le > CNT_W'(MID));
		end
	end

	// medians, zero for an index out of range
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			med_q <= '0;
		end else if (cmd.rank_en) begin
			for (int a = 0; a < AXES; a++) begin
				if (hit[a]) med_q[a] <= cand[a];
			end
		end
	end

	assign diff       = (med_q != prev_q[point_row]);
	assign change_now = change_seen_q || (idx_ok && diff);

	// previous medians, change flag and slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < POINTS; p++) prev_q[p] <= '0;
			change_seen_q <= 1'b0;
			slot_q        <= '0;
		end else if (cmd.emit) begin
			if (idx_ok) prev_q[point_row] <= med_q;
			if (fe_q) begin
				change_seen_q <= 1'b0;
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
			end else begin
				change_seen_q <= change_now;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index     <= idx_q;
			median_x      <= to_field(med_q[0]);
			median_y      <= to_field(med_q[1]);
			median_z      <= to_field(med_q[2]);
			frame_changed <= fe_q && change_now;
			out_frame_end <= fe_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.idx_ok   = idx_ok;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/keypoint_temporal_median_filter.sv =====
// Keypoint temporal median filter: each accepted point is written into the current window
// slot, then its WINDOW stored samples per axis are read back one slot a cycle from a single
// RAM read port and ranked one candidate a cycle; a point whose index is out of range skips
// the read and rank steps and goes straight to the result. The next point is taken as soon
// as a result has moved into the output register, whether or not it has been transferred out.
// Window store and previous medians read as zero after reset, with no clearing pass.
module keypoint_temporal_median_filter import ktmf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ktmf_pt_if.sink    points,
	ktmf_med_if.source medians
);

	ktmf_cmd_t cmd;
	ktmf_sts_t sts;

	// sequencer
	ktmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_ready (points.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and arithmetic
	ktmf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_index      (points.point_index),
		.in_x          (points.coord_x),
		.in_y          (points.coord_y),
		.in_z          (points.coord_z),
		.in_frame_end  (points.frame_end),
		.out_valid     (medians.valid),
		.out_ready     (medians.ready),
		.out_index     (medians.out_index),
		.median_x      (medians.median_x),
		.median_y      (medians.median_y),
		.median_z      (medians.median_z),
		.frame_changed (medians.frame_changed),
		.out_frame_end (medians.out_frame_end)
	);

endmodule

// ===== rtl/ktmf_chk.sv =====
// Port-level checks of the keypoint temporal median filter, bound to the top level.
// Depends on ktmf_pkg and on the top level's ports.
module ktmf_chk import ktmf_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [IDX_W-1:0]             out_index,
	input logic signed [FIELD_BITS-1:0] median_x,
	input logic signed [FIELD_BITS-1:0] median_y,
	input logic signed [FIELD_BITS-1:0] median_z,
	input logic                         frame_changed,
	input logic                         out_frame_end
);

	logic idx_bad;

	assign idx_bad = {1'b0, out_index} >= (IDX_W + 1)'(POINTS);

	// one point at a time: no transfer in straight after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer in");

	// change flag only on the last result of a frame
	a_change_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_changed || out_frame_end))
		else $error("frame_changed without out_frame_end");

	// unknown point gives zero medians
	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idx_bad |-> (median_x == '0) && (median_y == '0) && (median_z == '0))
		else $error("nonzero median for an index out of range");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(median_x)
			&& $stable(median_y) && $stable(median_z) && $stable(frame_changed)
			&& $stable(out_frame_end))
		else $error("result changed while stalled");

endmodule

bind keypoint_temporal_median_filter ktmf_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (points.valid),
	.in_ready      (points.ready),
	.out_valid     (medians.valid),
	.out_ready     (medians.ready),
	.out_index     (medians.out_index),
	.median_x      (medians.median_x),
	.median_y      (medians.median_y),
	.median_z      (medians.median_z),
	.frame_changed (medians.frame_changed),
	.out_frame_end (medians.out_frame_end)
);
